FILE: hw/rtl/srlp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srlp_pkg
// Shared types, codes and decode helpers for the S-record line parser.
// ----------------------------------------------------------------------------
package srlp_pkg;

    // ascii characters of interest
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;

    localparam int         POS_W      = 10;
    localparam logic [POS_W-1:0] POS_MAX = 10'd1023;
    localparam logic [10:0] MIN_LEN   = 11'd10;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_START = 3'd1;
    localparam logic [2:0] ST_CHECKSUM  = 3'd2;
    localparam logic [2:0] ST_BAD_LEN   = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;

    // item kinds
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // type digit codes
    localparam logic [3:0] TYPE_S1      = 4'd1;
    localparam logic [3:0] TYPE_S2      = 4'd2;
    localparam logic [3:0] TYPE_S3      = 4'd3;
    localparam logic [3:0] TYPE_S4      = 4'd4;
    localparam logic [3:0] TYPE_S7      = 4'd7;
    localparam logic [3:0] TYPE_S8      = 4'd8;
    localparam logic [3:0] TYPE_S9      = 4'd9;
    localparam logic [3:0] TYPE_NONDIG  = 4'd15;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_line;
    } t_in_word;

    typedef struct packed {
        logic        item_kind;
        logic [31:0] address;
        logic [7:0]  data_byte;
        logic [3:0]  record_type;
        logic [7:0]  data_count;
        logic [2:0]  status;
        logic        record_last;
    } t_out_word;

    // case-insensitive hex digit, anything else decodes as zero
    function automatic logic [3:0] hex_value(input logic [7:0] ch);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (ch >= CHAR_UP_A && ch <= CHAR_UP_F) begin
                v = ch - CHAR_UP_A + 8'd10;
            end else if (ch >= CHAR_LO_A && ch <= CHAR_LO_F) begin
                v = ch - CHAR_LO_A + 8'd10;
            end else if (ch >= CHAR_0 && ch <= CHAR_9) begin
                v = ch - CHAR_0;
            end
            return v[3:0];
        end
    endfunction

    // address bytes carried by a record type
    function automatic logic [2:0] addr_bytes(input logic [3:0] t);
        begin
            case (t)
                TYPE_S1, TYPE_S9: return 3'd2;
                TYPE_S2, TYPE_S8: return 3'd3;
                TYPE_S3, TYPE_S7: return 3'd4;
                default:          return 3'd0;
            endcase
        end
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/srlp_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srlp_in_stage
// Input register holding one character word until the parser takes it.
// ----------------------------------------------------------------------------
module srlp_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire srlp_pkg::t_in_word i_in_word,
    input  wire logic              i_take,
    output logic                   o_valid,
    output srlp_pkg::t_in_word     o_word
);
    import srlp_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    assign o_in_ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_word     = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_word <= i_in_word;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/srlp_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srlp_parse
// Per-line parser state and the single-pass decode of one character.
// ----------------------------------------------------------------------------
module srlp_parse (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire srlp_pkg::t_in_word i_word,
    output logic                    o_res_valid,
    output srlp_pkg::t_out_word     o_res
);
    import srlp_pkg::*;

    logic [POS_W-1:0] r_char_pos, n_char_pos;
    logic [3:0]       r_type, n_type;
    logic [7:0]       r_count, n_count;
    logic [3:0]       r_high, n_high;
    logic [7:0]       r_sum, n_sum;
    logic [31:0]      r_addr, n_addr;
    logic [7:0]       r_data_idx, n_data_idx;
    logic             r_err, n_err;

    logic [3:0]  hex;
    logic [7:0]  byte_val;
    logic [7:0]  byte_taken;
    logic        is_pair_end;
    logic [9:0]  pos_m3;
    logic [8:0]  byte_idx;
    logic [2:0]  na;
    logic        have_data;
    logic [10:0] line_len;
    logic [10:0] exp_len;
    logic [2:0]  st;
    logic [3:0]  code;
    logic        eol;

    assign eol         = i_word.end_of_line;
    assign hex         = hex_value(i_word.character);
    assign byte_val    = {r_high, hex};
    assign is_pair_end = r_char_pos[0] && (r_char_pos != 10'd1);
    assign byte_taken  = is_pair_end ? byte_val : 8'd0;
    assign pos_m3      = r_char_pos - 10'd3;
    assign byte_idx    = pos_m3[9:1];
    assign na          = addr_bytes(r_type);

    always_comb begin
        n_char_pos = r_char_pos;
        n_type     = r_type;
        n_count    = r_count;
        n_high     = r_high;
        n_sum      = r_sum;
        n_addr     = r_addr;
        n_data_idx = r_data_idx;
        n_err      = r_err;
        have_data  = 1'b0;

        if (r_char_pos == '0) begin
            if (i_word.character != CHAR_S) begin
                n_err = 1'b1;
            end
        end else if (r_char_pos == 10'd1) begin
            if (i_word.character >= CHAR_0 && i_word.character <= CHAR_9) begin
                n_type = i_word.character[3:0];
            end else begin
                n_type = TYPE_NONDIG;
            end
        end else if (!r_char_pos[0]) begin
            n_high = hex;
        end else begin
            if (byte_idx == '0) begin
                n_count = byte_val;
                n_sum   = r_sum + byte_val;
            end else if (byte_idx < {1'b0, r_count}) begin
                n_sum = r_sum + byte_val;
                if (byte_idx <= {6'd0, na}) begin
                    n_addr = {r_addr[23:0], byte_val};
                end else if (r_type >= TYPE_S1 && r_type <= TYPE_S3 && !r_err) begin
                    have_data = 1'b1;
                end
            end
        end

        // summary status, in priority order
        line_len = {1'b0, r_char_pos} + 11'd1;
        exp_len  = {2'b00, n_count, 1'b0} + 11'd4;
        if (n_err) begin
            st = ST_BAD_START;
        end else if (line_len < MIN_LEN || line_len != exp_len) begin
            st = ST_BAD_LEN;
        end else if (byte_taken != ~n_sum) begin
            st = ST_CHECKSUM;
        end else if (n_type > TYPE_S9 || n_type == TYPE_S4) begin
            st = ST_UNKNOWN;
        end else begin
            st = ST_OK;
        end
        if (st != ST_OK) begin
            code = 4'd0;
        end else if (n_type < TYPE_S4) begin
            code = n_type + 4'd1;
        end else begin
            code = n_type;
        end

        o_res = '0;
        if (eol) begin
            o_res.item_kind   = KIND_SUMMARY;
            o_res.address     = n_addr;
            o_res.record_type = code;
            o_res.data_count  = r_data_idx;
            o_res.status      = st;
            o_res.record_last = 1'b1;
        end else begin
            o_res.item_kind = KIND_DATA;
            o_res.address   = r_addr + {24'd0, r_data_idx};
            o_res.data_byte = byte_val;
        end
        o_res_valid = i_step && (eol || have_data);

        if (eol) begin
            n_char_pos = '0;
            n_type     = '0;
            n_count    = '0;
            n_high     = '0;
            n_sum      = '0;
            n_addr     = '0;
            n_data_idx = '0;
            n_err      = 1'b0;
        end else begin
            if (r_char_pos != POS_MAX) begin
                n_char_pos = r_char_pos + 10'd1;
            end
            if (have_data) begin
                n_data_idx = r_data_idx + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_pos <= '0;
            r_type     <= '0;
            r_count    <= '0;
            r_high     <= '0;
            r_sum      <= '0;
            r_addr     <= '0;
            r_data_idx <= '0;
            r_err      <= 1'b0;
        end else if (i_step) begin
            r_char_pos <= n_char_pos;
            r_type     <= n_type;
            r_count    <= n_count;
            r_high     <= n_high;
            r_sum      <= n_sum;
            r_addr     <= n_addr;
            r_data_idx <= n_data_idx;
            r_err      <= n_err;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/srlp_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srlp_out_stage
// Result register presenting one output word until the consumer takes it.
// ----------------------------------------------------------------------------
module srlp_out_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire srlp_pkg::t_out_word i_word,
    output logic                     o_free,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output srlp_pkg::t_out_word      o_out_word
);
    import srlp_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_word <= i_word;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/srecord_line_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srecord_line_parser_core
// Motorola S-record line parser: one ASCII character word in per cycle when
// not stalled, tentative data bytes and a per-line summary word out.
// ----------------------------------------------------------------------------
// data path: input register, single-pass decode, result register, output
// throughput: 1 character per cycle when not back-pressured, set by the
//   single-pass decode between the input register and the result register
// reset: synchronous active-low i_rst_n clears both valid flags and all
//   per-line parser state; no clearing pass is needed
// ----------------------------------------------------------------------------
module srecord_line_parser_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // character stream
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire srlp_pkg::t_in_word  i_in_word,
    // result stream
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output srlp_pkg::t_out_word      o_out_word
);
    import srlp_pkg::*;

    logic      stg_valid;
    t_in_word  stg_word;
    logic      out_free;
    logic      step;
    logic      res_valid;
    t_out_word res_word;

    // a staged character moves on only when the result register can take
    // whatever it produces, so nothing is dropped under back-pressure
    assign step = stg_valid && out_free;

    // input register
    srlp_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_take     (step),
        .o_valid    (stg_valid),
        .o_word     (stg_word)
    );

    // parser state and per-character decode; emits a data word or the
    // line summary, or nothing otherwise (header, count, address, checksum)
    srlp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_word      (stg_word),
        .o_res_valid (res_valid),
        .o_res       (res_word)
    );

    // result register, holds each output word until the consumer takes it
    srlp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_valid),
        .i_word      (res_word),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
`default_nettype wire
